>>> rtl/quoted_option_line_tokenizer_assert.svh
// Assertion macros shared by the tokenizer checker.
`ifndef QUOTED_OPTION_LINE_TOKENIZER_ASSERT_SVH
`define QUOTED_OPTION_LINE_TOKENIZER_ASSERT_SVH

// Implication checked in the same cycle.
`define QOLT_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tokenizer check failed");

// Implication checked in the next cycle.
`define QOLT_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("tokenizer check failed");

`endif

>>> rtl/qolt_pkg.sv
// Types, constants and helper functions of the quoted option line tokenizer.
package qolt_pkg;

   localparam int MAX_PARAMS_DEF  = 16;
   localparam int PARAM_CHARS_DEF = 256;
   localparam int CFG_W           = 5;
   localparam logic [CFG_W-1:0] PARAM_LIMIT_RESET = 5'd16;
   localparam int FIFO_DEPTH      = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;

   typedef enum logic [2:0] {
      PH_BETWEEN = 3'd0,
      PH_DQUOTE  = 3'd1,
      PH_BARE    = 3'd2,
      PH_SKIP    = 3'd3,
      PH_SQUOTE  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_LINE = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_ESC   = 3'd1,
      ST_TOO_LONG  = 3'd2,
      ST_OPEN_DQ   = 3'd3,
      ST_OPEN_SQ   = 3'd4,
      ST_RESIDUAL  = 3'd5
   } status_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] param_char;
      logic [3:0] param_index;
      logic [4:0] param_total;
      status_type line_status;
      logic       last;
   } rsp_type;

   // Up to two responses written into the output queue in the same cycle.
   typedef struct packed {
      logic [1:0] cnt;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_NUL) || (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic status_type phase_status(input phase_type ph);
      status_type st;
      unique case (ph)
         PH_BETWEEN: st = ST_OK;
         PH_DQUOTE:  st = ST_OPEN_DQ;
         PH_SQUOTE:  st = ST_OPEN_SQ;
         default:    st = ST_RESIDUAL;
      endcase
      return st;
   endfunction

endpackage

>>> rtl/qolt_scan.sv
// Tokenizer state and the per-character decode that produces the responses.
module qolt_scan #(
   parameter int MAX_PARAMS  = qolt_pkg::MAX_PARAMS_DEF,
   parameter int PARAM_CHARS = qolt_pkg::PARAM_CHARS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [7:0]                  char_code,
   input  logic [qolt_pkg::CFG_W-1:0]  param_limit,
   output qolt_pkg::push_type          push
);
   import qolt_pkg::*;

   localparam int PD_W  = $clog2(MAX_PARAMS + 1);
   localparam int CC_W  = $clog2(PARAM_CHARS + 1);
   localparam int CMP_W = (PD_W > CFG_W) ? PD_W : CFG_W;

   phase_type         phase_ff, phase_in;
   logic              esc_ff, esc_in;
   logic [CC_W-1:0]   cc_ff, cc_in;
   logic [PD_W-1:0]   pd_ff, pd_in;
   status_type        ek_ff, ek_in;

   logic              active, esc_start, consumed, have, done, stop_mark;
   logic              bad_esc, long_err, emit_char, lim_stop, any_stop, line_end;
   phase_type         phase_mid, phase_fin;
   status_type        err, ek_fin, line_st;
   logic [PD_W-1:0]   pd_mid;
   logic [CMP_W-1:0]  lim_eff;
   rsp_type           char_rsp, end_rsp, line_rsp;

   // Decode of the current character against the current phase.
   always_comb begin
      active    = (phase_ff != PH_SKIP);
      esc_start = 1'b0;
      have      = 1'b0;
      done      = 1'b0;
      stop_mark = 1'b0;
      phase_mid = phase_ff;
      if (active) begin
         if (!esc_ff && (char_code == CH_BSL) && (phase_ff != PH_SQUOTE)) begin
            esc_start = 1'b1;
         end else begin
            unique case (phase_ff)
               PH_BETWEEN: begin
                  if (!is_blank(char_code)) begin
                     if ((char_code == CH_SEMI) || (char_code == CH_HASH)) begin
                        stop_mark = 1'b1;
                     end else if (!esc_ff && (char_code == CH_DQ)) begin
                        phase_mid = PH_DQUOTE;
                     end else if (!esc_ff && (char_code == CH_SQ)) begin
                        phase_mid = PH_SQUOTE;
                     end else begin
                        have      = 1'b1;
                        phase_mid = PH_BARE;
                     end
                  end
               end
               PH_BARE: begin
                  if (!esc_ff && is_blank(char_code)) done = 1'b1;
                  else have = (char_code != CH_NUL);
               end
               PH_DQUOTE: begin
                  if (!esc_ff && (char_code == CH_DQ)) done = 1'b1;
                  else have = (char_code != CH_NUL);
               end
               default: begin
                  if (char_code == CH_SQ) done = 1'b1;
                  else have = (char_code != CH_NUL);
               end
            endcase
            if (done) phase_mid = PH_BETWEEN;
         end
      end
      consumed  = active && !esc_start;
      pd_mid    = done ? PD_W'(pd_ff + 1'b1) : pd_ff;
      bad_esc   = consumed && !stop_mark && esc_ff && have &&
                  !((char_code == CH_BSL) || (char_code == CH_DQ) || is_blank(char_code));
      long_err  = active && !stop_mark && !bad_esc && have &&
                  (cc_ff >= CC_W'(PARAM_CHARS));
      emit_char = active && !stop_mark && !bad_esc && have && !long_err;
      err       = bad_esc ? ST_BAD_ESC : (long_err ? ST_TOO_LONG : ST_OK);
      lim_eff   = (CMP_W'(param_limit) > CMP_W'(MAX_PARAMS)) ? CMP_W'(MAX_PARAMS)
                                                              : CMP_W'(param_limit);
      lim_stop  = active && !stop_mark && (err == ST_OK) && (CMP_W'(pd_mid) >= lim_eff);
      any_stop  = stop_mark || lim_stop;
      phase_fin = ((err != ST_OK) || any_stop) ? PH_SKIP : phase_mid;
      ek_fin    = (err != ST_OK) ? err : (any_stop ? phase_status(phase_mid) : ek_ff);
      line_end  = (char_code == CH_NUL);
      line_st   = (phase_fin == PH_SKIP) ? ek_fin : phase_status(phase_fin);
   end

   // Next state.
   always_comb begin
      if (line_end) begin
         phase_in = PH_BETWEEN;
         esc_in   = 1'b0;
         cc_in    = '0;
         pd_in    = '0;
         ek_in    = ST_OK;
      end else begin
         phase_in = phase_fin;
         esc_in   = esc_start ? 1'b1 : ((consumed && !stop_mark) ? 1'b0 : esc_ff);
         cc_in    = done ? '0 : (emit_char ? CC_W'(cc_ff + 1'b1) : cc_ff);
         pd_in    = pd_mid;
         ek_in    = ek_fin;
      end
   end

   // Responses: a character or a parameter end, then possibly the line result.
   always_comb begin
      char_rsp             = '0;
      char_rsp.kind        = KIND_CHAR;
      char_rsp.param_char  = char_code;
      char_rsp.param_index = 4'(pd_mid);
      char_rsp.line_status = ST_OK;
      char_rsp.last        = !line_end;

      end_rsp              = '0;
      end_rsp.kind         = KIND_END;
      end_rsp.param_index  = 4'(pd_ff);
      end_rsp.line_status  = ST_OK;
      end_rsp.last         = !line_end;

      line_rsp             = '0;
      line_rsp.kind        = KIND_LINE;
      line_rsp.param_total = (line_st == ST_OK) ? 5'(pd_mid) : 5'd0;
      line_rsp.line_status = line_st;
      line_rsp.last        = 1'b1;

      push        = '0;
      push.first  = emit_char ? char_rsp : (done ? end_rsp : line_rsp);
      push.second = line_rsp;
      if (step) begin
         push.cnt = 2'((emit_char || done) ? 1 : 0) + 2'(line_end ? 1 : 0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         esc_ff   <= 1'b0;
         cc_ff    <= '0;
         pd_ff    <= '0;
         ek_ff    <= ST_OK;
      end else if (step) begin
         phase_ff <= phase_in;
         esc_ff   <= esc_in;
         cc_ff    <= cc_in;
         pd_ff    <= pd_in;
         ek_ff    <= ek_in;
      end
   end

endmodule

>>> rtl/qolt_rsp_fifo.sv
// Small response queue that takes up to two responses a cycle and gives one.
module qolt_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  qolt_pkg::push_type push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output qolt_pkg::rsp_type  rsp_data
);
   import qolt_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   rsp_type           mem [FIFO_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;
   // Room for two more responses regardless of what leaves this cycle.
   assign room      = (count_ff <= CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = PTR_W'(wr_ptr_ff + PTR_W'(push.cnt));
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = CNT_W'(count_ff + CNT_W'(push.cnt) - CNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (push.cnt != 2'd0) mem[wr_ptr_ff] <= push.first;
      if (push.cnt == 2'd2) mem[PTR_W'(wr_ptr_ff + 1'b1)] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/quoted_option_line_tokenizer.sv
// A request is registered, decoded and queued in a four-entry response queue.
// Throughput: one request per cycle while the queue has room; a line end that
//   also closes a word gives two responses, read one per cycle on rsp_ready.
// The input register stalls only while that queue holds more than two responses.
// Reset is synchronous: it empties the queue, clears the line state and sets
//   param_limit to 16.
module quoted_option_line_tokenizer #(
   parameter int MAX_PARAMS  = qolt_pkg::MAX_PARAMS_DEF,
   parameter int PARAM_CHARS = qolt_pkg::PARAM_CHARS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_char_code,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [1:0]                 rsp_kind,
   output logic [7:0]                 rsp_param_char,
   output logic [3:0]                 rsp_param_index,
   output logic [4:0]                 rsp_param_total,
   output logic [2:0]                 rsp_line_status,
   output logic                       rsp_last,
   input  logic                       csr_wr_en,
   input  logic [qolt_pkg::CFG_W-1:0] csr_wr_data
);
   import qolt_pkg::*;

   logic             in_vld_ff, in_vld_in;
   logic [7:0]       char_ff;
   logic [CFG_W-1:0] limit_ff;
   logic             room, step;
   push_type         push;
   rsp_type          rsp_data;

   assign step      = in_vld_ff && room;
   assign req_ready = !in_vld_ff || step;
   assign in_vld_in = (req_valid && req_ready) ? 1'b1 : (step ? 1'b0 : in_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         limit_ff  <= PARAM_LIMIT_RESET;
      end else begin
         in_vld_ff <= in_vld_in;
         if (csr_wr_en) limit_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) char_ff <= req_char_code;
   end

   qolt_scan #(
      .MAX_PARAMS  (MAX_PARAMS),
      .PARAM_CHARS (PARAM_CHARS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_code   (char_ff),
      .param_limit (limit_ff),
      .push        (push)
   );

   qolt_rsp_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_param_char  = rsp_data.param_char;
   assign rsp_param_index = rsp_data.param_index;
   assign rsp_param_total = rsp_data.param_total;
   assign rsp_line_status = rsp_data.line_status;
   assign rsp_last        = rsp_data.last;

endmodule

>>> rtl/qolt_checker.sv
// Port-level checks of the tokenizer and their binding to the top level.
`include "quoted_option_line_tokenizer_assert.svh"

module qolt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_param_char,
   input logic [4:0] rsp_param_total,
   input logic [2:0] rsp_line_status,
   input logic       rsp_last
);
   import qolt_pkg::*;

   logic line_seen;
   logic char_seen;

   assign line_seen = rsp_valid && (rsp_kind == KIND_LINE);
   assign char_seen = rsp_valid && (rsp_kind == KIND_CHAR);

   `QOLT_ASSERT_NEXT(a_rsp_held, rsp_valid && !rsp_ready, rsp_valid)
   `QOLT_ASSERT_NOW(a_line_last, line_seen, rsp_last)
   `QOLT_ASSERT_NOW(a_err_no_total, line_seen && (rsp_line_status != ST_OK), rsp_param_total == 5'd0)
   `QOLT_ASSERT_NOW(a_char_clean, char_seen, (rsp_param_char != 8'd0) && (rsp_line_status == ST_OK))
   `QOLT_ASSERT_NOW(a_nonchar_zero, rsp_valid && (rsp_kind != KIND_CHAR), rsp_param_char == 8'd0)

endmodule

bind quoted_option_line_tokenizer qolt_checker u_checker (.*);
